// ===== rtl/ihre_pkg.sv =====
// Shared types, codes and character tables for the Intel HEX record emitter.
package ihre_pkg;

    localparam int BUF_DEPTH            = 16;
    localparam int RECORD_BYTES_DEFAULT = 16;
    localparam int END_LEN              = 12;

    localparam logic [1:0] MODE_DATA   = 2'd0;
    localparam logic [1:0] MODE_ADDR   = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    localparam logic [3:0] SEL_COLON = 4'd0;
    localparam logic [3:0] SEL_CNT_H = 4'd1;
    localparam logic [3:0] SEL_CNT_L = 4'd2;
    localparam logic [3:0] SEL_AH_H  = 4'd3;
    localparam logic [3:0] SEL_AH_L  = 4'd4;
    localparam logic [3:0] SEL_AL_H  = 4'd5;
    localparam logic [3:0] SEL_AL_L  = 4'd6;
    localparam logic [3:0] SEL_ZERO  = 4'd7;
    localparam logic [3:0] SEL_DAT_H = 4'd8;
    localparam logic [3:0] SEL_DAT_L = 4'd9;
    localparam logic [3:0] SEL_SUM_H = 4'd10;
    localparam logic [3:0] SEL_SUM_L = 4'd11;
    localparam logic [3:0] SEL_LF    = 4'd12;
    localparam logic [3:0] SEL_END   = 4'd13;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    typedef struct packed {
        logic       emit;
        logic [3:0] sel;
        logic       last;
        logic [3:0] end_idx;
        logic       rd_en;
        logic [3:0] rd_idx;
        logic       sum_init;
        logic       sum_add;
        logic       flush_done;
        logic       load_addr;
    } cmd_t;

    typedef struct packed {
        logic [4:0] fill;
        logic       can_emit;
    } stat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        hex_char = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
    endfunction

    // End record ":00000001FF" plus line feed
    function automatic logic [7:0] end_char(input logic [3:0] idx);
        case (idx)
            4'd0:    end_char = CHAR_COLON;
            4'd8:    end_char = 8'h31;
            4'd9:    end_char = 8'h46;
            4'd10:   end_char = 8'h46;
            4'd11:   end_char = CHAR_LF;
            default: end_char = CHAR_ZERO;
        endcase
    endfunction

endpackage

// ===== rtl/ihre_in_if.sv =====
// Input channel: command beats with mode, data byte and load address.
interface ihre_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic [15:0] new_address;

    modport source (output valid, output mode, output data_byte, output new_address,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input new_address,
                    output ready);
endinterface

// ===== rtl/ihre_out_if.sv =====
// Output channel: one ASCII character beat with a last flag.
interface ihre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ===== rtl/ihre_ctrl.sv =====
// Record sequencer: walks the characters of data and end records.
module ihre_ctrl
    import ihre_pkg::*;
#(
    parameter int RECORD_BYTES = RECORD_BYTES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [1:0] mode,
    input  stat_t      stat,
    output logic       idle,
    output cmd_t       cmd
);

    localparam int REC_LIMIT = (RECORD_BYTES < 1) ? 1 :
                               ((RECORD_BYTES > BUF_DEPTH) ? BUF_DEPTH : RECORD_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_COLON = 4'd1;
    localparam logic [3:0] S_CNT_H = 4'd2;
    localparam logic [3:0] S_CNT_L = 4'd3;
    localparam logic [3:0] S_AH_H  = 4'd4;
    localparam logic [3:0] S_AH_L  = 4'd5;
    localparam logic [3:0] S_AL_H  = 4'd6;
    localparam logic [3:0] S_AL_L  = 4'd7;
    localparam logic [3:0] S_Z0    = 4'd8;
    localparam logic [3:0] S_Z1    = 4'd9;
    localparam logic [3:0] S_DHI   = 4'd10;
    localparam logic [3:0] S_DLO   = 4'd11;
    localparam logic [3:0] S_SUM_H = 4'd12;
    localparam logic [3:0] S_SUM_L = 4'd13;
    localparam logic [3:0] S_LF    = 4'd14;
    localparam logic [3:0] S_ENDR  = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [1:0] pend_mode_reg, pend_mode_next;
    logic [3:0] byte_cnt_reg, byte_cnt_next;
    logic [3:0] end_idx_reg, end_idx_next;
    logic [5:0] fill_inc;
    logic [4:0] byte_cnt_inc;
    logic       go;

    assign fill_inc     = {1'b0, stat.fill} + 6'd1;
    assign byte_cnt_inc = {1'b0, byte_cnt_reg} + 5'd1;
    assign go           = stat.can_emit;
    assign idle         = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        pend_mode_next = pend_mode_reg;
        byte_cnt_next  = byte_cnt_reg;
        end_idx_next   = end_idx_reg;
        cmd            = '0;
        cmd.end_idx    = end_idx_reg;
        cmd.emit       = (state_reg != S_IDLE) && go;

        unique case (state_reg)
            S_IDLE:
            begin
                end_idx_next = '0;
                if (accept)
                begin
                    unique case (mode)
                        MODE_DATA:
                        begin
                            if (fill_inc >= 6'(REC_LIMIT))
                            begin
                                state_next     = S_COLON;
                                pend_mode_next = MODE_DATA;
                            end
                        end
                        MODE_ADDR:
                        begin
                            if (stat.fill != 5'd0)
                            begin
                                state_next     = S_COLON;
                                pend_mode_next = MODE_ADDR;
                            end
                        end
                        MODE_FINISH:
                        begin
                            pend_mode_next = MODE_FINISH;
                            state_next     = (stat.fill != 5'd0) ? S_COLON : S_ENDR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_COLON:
            begin
                cmd.sel      = SEL_COLON;
                cmd.rd_en    = 1'b1;
                cmd.rd_idx   = '0;
                cmd.sum_init = 1'b1;
                if (go)
                begin
                    byte_cnt_next = '0;
                    state_next    = S_CNT_H;
                end
            end
            S_CNT_H:
            begin
                cmd.sel = SEL_CNT_H;
                if (go) state_next = S_CNT_L;
            end
            S_CNT_L:
            begin
                cmd.sel = SEL_CNT_L;
                if (go) state_next = S_AH_H;
            end
            S_AH_H:
            begin
                cmd.sel = SEL_AH_H;
                if (go) state_next = S_AH_L;
            end
            S_AH_L:
            begin
                cmd.sel = SEL_AH_L;
                if (go) state_next = S_AL_H;
            end
            S_AL_H:
            begin
                cmd.sel = SEL_AL_H;
                if (go) state_next = S_AL_L;
            end
            S_AL_L:
            begin
                cmd.sel = SEL_AL_L;
                if (go) state_next = S_Z0;
            end
            S_Z0:
            begin
                cmd.sel = SEL_ZERO;
                if (go) state_next = S_Z1;
            end
            S_Z1:
            begin
                cmd.sel = SEL_ZERO;
                if (go) state_next = S_DHI;
            end
            S_DHI:
            begin
                cmd.sel = SEL_DAT_H;
                if (go) state_next = S_DLO;
            end
            S_DLO:
            begin
                cmd.sel     = SEL_DAT_L;
                cmd.sum_add = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_idx  = byte_cnt_inc[3:0];
                if (go)
                begin
                    byte_cnt_next = byte_cnt_inc[3:0];
                    state_next    = (byte_cnt_inc == stat.fill) ? S_SUM_H : S_DHI;
                end
            end
            S_SUM_H:
            begin
                cmd.sel = SEL_SUM_H;
                if (go) state_next = S_SUM_L;
            end
            S_SUM_L:
            begin
                cmd.sel = SEL_SUM_L;
                if (go) state_next = S_LF;
            end
            S_LF:
            begin
                cmd.sel        = SEL_LF;
                cmd.flush_done = 1'b1;
                cmd.last       = (pend_mode_reg != MODE_FINISH);
                cmd.load_addr  = (pend_mode_reg == MODE_ADDR);
                if (go) state_next = (pend_mode_reg == MODE_FINISH) ? S_ENDR : S_IDLE;
            end
            S_ENDR:
            begin
                cmd.sel  = SEL_END;
                cmd.last = (end_idx_reg == 4'(END_LEN - 1));
                if (go)
                begin
                    end_idx_next = end_idx_reg + 4'd1;
                    if (end_idx_reg == 4'(END_LEN - 1)) state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_mode_reg <= MODE_DATA;
            byte_cnt_reg  <= '0;
            end_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_mode_reg <= pend_mode_next;
            byte_cnt_reg  <= byte_cnt_next;
            end_idx_reg   <= end_idx_next;
        end
    end

endmodule

// ===== rtl/ihre_dp.sv =====
// Datapath: byte buffer, address, checksum, character mux and output register.
module ihre_dp
    import ihre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    input  logic [15:0] new_address,
    input  cmd_t        cmd,
    output stat_t       stat,
    ihre_out_if.source  out_ch
);

    logic [7:0]  mem [BUF_DEPTH];
    logic [7:0]  rd_data_reg;
    logic [4:0]  fill_reg, fill_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] pend_addr_reg;
    logic [7:0]  sum_reg;
    logic [7:0]  count8;
    logic [7:0]  chk;
    logic [7:0]  char_sel;
    logic        out_valid_reg;
    logic [7:0]  out_char_reg;
    logic        out_last_reg;

    assign count8        = {3'd0, fill_reg};
    assign chk           = 8'd0 - sum_reg;
    assign stat.fill     = fill_reg;
    assign stat.can_emit = !out_valid_reg || out_ch.ready;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_char  = out_char_reg;
    assign out_ch.last_char = out_last_reg;

    // Buffer write on data beats, registered read for the record walk
    always_ff @(posedge clk)
    begin
        if (accept && (mode == MODE_DATA) && !fill_reg[4])
            mem[fill_reg[3:0]] <= data_byte;
        if (cmd.emit && cmd.rd_en)
            rd_data_reg <= mem[cmd.rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (accept && (mode == MODE_ADDR))
            pend_addr_reg <= new_address;
        if (cmd.emit && cmd.sum_init)
            sum_reg <= count8 + addr_reg[15:8] + addr_reg[7:0];
        else if (cmd.emit && cmd.sum_add)
            sum_reg <= sum_reg + rd_data_reg;
    end

    always_comb
    begin
        fill_next = fill_reg;
        addr_next = addr_reg;
        if (accept && (mode == MODE_DATA))
            fill_next = fill_reg + 5'd1;
        if (accept && (mode == MODE_ADDR) && (fill_reg == 5'd0))
            addr_next = new_address;
        if (cmd.emit && cmd.flush_done)
        begin
            fill_next = '0;
            addr_next = cmd.load_addr ? pend_addr_reg : (addr_reg + {11'd0, fill_reg});
        end
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_COLON: char_sel = CHAR_COLON;
            SEL_CNT_H: char_sel = hex_char(count8[7:4]);
            SEL_CNT_L: char_sel = hex_char(count8[3:0]);
            SEL_AH_H:  char_sel = hex_char(addr_reg[15:12]);
            SEL_AH_L:  char_sel = hex_char(addr_reg[11:8]);
            SEL_AL_H:  char_sel = hex_char(addr_reg[7:4]);
            SEL_AL_L:  char_sel = hex_char(addr_reg[3:0]);
            SEL_ZERO:  char_sel = CHAR_ZERO;
            SEL_DAT_H: char_sel = hex_char(rd_data_reg[7:4]);
            SEL_DAT_L: char_sel = hex_char(rd_data_reg[3:0]);
            SEL_SUM_H: char_sel = hex_char(chk[7:4]);
            SEL_SUM_L: char_sel = hex_char(chk[3:0]);
            SEL_LF:    char_sel = CHAR_LF;
            SEL_END:   char_sel = end_char(cmd.end_idx);
            default:   char_sel = CHAR_ZERO;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg <= char_sel;
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            addr_reg      <= 16'hFFFF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            addr_reg <= addr_next;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/intel_hex_record_emitter_top.sv =====
// Top level of the Intel HEX record emitter: sequencer plus datapath.
//
// channel  dir  payload                         beat
// in_ch    in   mode, data_byte, new_address    one command
// out_ch   out  out_char, last_char             one ASCII character
//
// A command beat is taken while the sequencer is idle; a data byte that does not
// fill the buffer leaves the sequencer idle.
// A data record of N bytes then streams 12 + 2*N characters and the end record
// 12 more, one per cycle while out_ch is ready, paced by the datapath's single
// character register. Input ready stays low while a record is being written out.
// Reset (rst_n, asynchronous, active low) empties the buffer and sets the
// address to 0xFFFF; buffer contents need no clearing since only filled entries
// are used. Backpressure on out_ch holds the character register and the sequencer.
module intel_hex_record_emitter_top
    import ihre_pkg::*;
#(
    parameter int RECORD_BYTES = RECORD_BYTES_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    ihre_in_if.sink   in_ch,
    ihre_out_if.source out_ch
);

    cmd_t  cmd;
    stat_t stat;
    logic  idle;
    logic  accept;

    // Take commands only between records
    assign in_ch.ready = idle;
    assign accept      = in_ch.valid && idle;

    ihre_ctrl #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .mode   (in_ch.mode),
        .stat   (stat),
        .idle   (idle),
        .cmd    (cmd)
    );

    ihre_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (in_ch.mode),
        .data_byte   (in_ch.data_byte),
        .new_address (in_ch.new_address),
        .cmd         (cmd),
        .stat        (stat),
        .out_ch      (out_ch)
    );

endmodule
